/* rtl/ticketed_chunk_reassembly_tracker_macros.svh */
// Assertion macros for the ticketed chunk reassembly tracker.
// Included by the top level; depends on nothing else.
`ifndef TICKETED_CHUNK_REASSEMBLY_TRACKER_MACROS_SVH
`define TICKETED_CHUNK_REASSEMBLY_TRACKER_MACROS_SVH

// same-cycle implication, clocked and reset-qualified
`define TCRT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcrt assertion failed");

// next-cycle implication, clocked and reset-qualified
`define TCRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcrt assertion failed");

`endif

/* rtl/tcrt_pkg.sv */
// Shared types and constants for the ticketed chunk reassembly tracker.
// Used by tcrt_table, tcrt_decide and the top level; no dependencies.
`default_nettype none

package tcrt_pkg;

   localparam int MAX_TRANSFERS = 8;
   localparam int IDX_W = (MAX_TRANSFERS > 1) ? $clog2(MAX_TRANSFERS) : 1;
   localparam logic [31:0] MAX_BYTES_RESET = 32'd1048576;

   typedef enum logic [1:0] {
      ACT_ASK     = 2'd0,
      ACT_CHUNK   = 2'd1,
      ACT_REFUSAL = 2'd2,
      ACT_ABANDON = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_ASKED     = 4'd0,
      ST_FULL      = 4'd1,
      ST_SENDFAIL  = 4'd2,
      ST_STORED    = 4'd3,
      ST_COMPLETED = 4'd4,
      ST_REFUSED   = 4'd5,
      ST_TOOLARGE  = 4'd6,
      ST_DISCARDED = 4'd7,
      ST_ABANDONED = 4'd8
   } status_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic             has_free;
      logic [IDX_W-1:0] free_idx;
      logic             sized;
      logic [31:0]      total;
      logic [31:0]      filled;
   } lookup_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic             valid;
      logic             open;
      logic [63:0]      ticket;
      logic             sized;
      logic [31:0]      total;
      logic [31:0]      filled;
   } update_type;

   typedef struct packed {
      logic requests;
      logic chunks;
      logic completed;
      logic refused;
      logic discarded;
   } tally_inc_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  slot;
      logic [31:0] write_offset;
   } result_type;

   // low three bits of a table index, zero-extended for small tables
   function automatic logic [2:0] slot_bits(input logic [IDX_W-1:0] idx);
      logic [IDX_W+2:0] wide;
      wide = {3'b000, idx};
      return wide[2:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/tcrt_table.sv */
// Transfer table: per-entry ticket, size and fill, with parallel ticket match
// and free-slot search. Depends on tcrt_pkg.
`default_nettype none

module tcrt_table (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [63:0]          ticket,
   input  wire tcrt_pkg::update_type upd,
   output tcrt_pkg::lookup_type      lkp
);

   logic [tcrt_pkg::MAX_TRANSFERS-1:0] valid_ff;
   logic [tcrt_pkg::MAX_TRANSFERS-1:0] valid_in;
   logic [63:0] ticket_ff [tcrt_pkg::MAX_TRANSFERS];
   logic        sized_ff  [tcrt_pkg::MAX_TRANSFERS];
   logic [31:0] total_ff  [tcrt_pkg::MAX_TRANSFERS];
   logic [31:0] filled_ff [tcrt_pkg::MAX_TRANSFERS];

   logic [tcrt_pkg::MAX_TRANSFERS-1:0] hit_vec;
   logic [tcrt_pkg::IDX_W-1:0]         hit_idx;
   logic [tcrt_pkg::IDX_W-1:0]         free_idx;

   always_comb begin
      for (int i = 0; i < tcrt_pkg::MAX_TRANSFERS; i++) begin
         hit_vec[i] = valid_ff[i] && (ticket_ff[i] == ticket);
      end
   end

   // lowest index wins for both searches
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = tcrt_pkg::MAX_TRANSFERS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = tcrt_pkg::IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = tcrt_pkg::IDX_W'(i);
         end
      end
   end

   always_comb begin
      lkp.hit      = |hit_vec;
      lkp.hit_idx  = hit_idx;
      lkp.has_free = ~&valid_ff;
      lkp.free_idx = free_idx;
      lkp.sized    = sized_ff[hit_idx];
      lkp.total    = total_ff[hit_idx];
      lkp.filled   = filled_ff[hit_idx];
   end

   always_comb begin
      valid_in = valid_ff;
      if (upd.en) begin
         valid_in[upd.idx] = upd.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd.en) begin
         if (upd.open) begin
            ticket_ff[upd.idx] <= upd.ticket;
         end
         sized_ff[upd.idx]  <= upd.sized;
         total_ff[upd.idx]  <= upd.total;
         filled_ff[upd.idx] <= upd.filled;
      end
   end

endmodule

`default_nettype wire

/* rtl/tcrt_decide.sv */
// Per-request decision logic: status, slot, write offset, table update and
// tally increments from one request and the table lookup. Depends on tcrt_pkg.
`default_nettype none

module tcrt_decide (
   input  wire logic                 go,
   input  wire logic [1:0]           action,
   input  wire logic [63:0]          ticket,
   input  wire logic                 send_ok,
   input  wire logic [31:0]          total_bytes,
   input  wire logic [31:0]          chunk_offset,
   input  wire logic [15:0]          chunk_length,
   input  wire logic [31:0]          max_bytes,
   input  wire tcrt_pkg::lookup_type lkp,
   output tcrt_pkg::update_type      upd,
   output tcrt_pkg::tally_inc_type   inc,
   output tcrt_pkg::result_type      res
);

   tcrt_pkg::action_type act;
   logic [31:0] eff_total;
   logic [32:0] fill_sum;
   logic [31:0] new_fill;
   logic        too_large;
   logic        total_bad;
   logic        place_ok;

   assign act       = tcrt_pkg::action_type'(action);
   assign too_large = !lkp.sized && (total_bytes > max_bytes);
   assign total_bad = lkp.sized && (lkp.total != total_bytes);
   assign eff_total = lkp.sized ? lkp.total : total_bytes;
   assign fill_sum  = {1'b0, lkp.filled} + 33'(chunk_length);
   assign new_fill  = fill_sum[31:0];
   assign place_ok  = (chunk_offset == lkp.filled) && (fill_sum <= {1'b0, eff_total});

   always_comb begin
      res.status       = tcrt_pkg::ST_DISCARDED;
      res.slot         = 3'd0;
      res.write_offset = '0;
      inc              = '0;
      upd.en           = 1'b0;
      upd.idx          = lkp.hit_idx;
      upd.valid        = 1'b1;
      upd.open         = 1'b0;
      upd.ticket       = ticket;
      upd.sized        = lkp.sized;
      upd.total        = lkp.total;
      upd.filled       = lkp.filled;

      unique case (act)
         tcrt_pkg::ACT_ASK: begin
            if (!lkp.hit && !lkp.has_free) begin
               res.status = tcrt_pkg::ST_FULL;
            end else if (!send_ok) begin
               res.status = tcrt_pkg::ST_SENDFAIL;
            end else begin
               res.status   = tcrt_pkg::ST_ASKED;
               inc.requests = 1'b1;
               if (lkp.hit) begin
                  res.slot = tcrt_pkg::slot_bits(lkp.hit_idx);
               end else begin
                  res.slot   = tcrt_pkg::slot_bits(lkp.free_idx);
                  upd.en     = 1'b1;
                  upd.idx    = lkp.free_idx;
                  upd.open   = 1'b1;
                  upd.sized  = 1'b0;
                  upd.total  = '0;
                  upd.filled = '0;
               end
            end
         end
         tcrt_pkg::ACT_CHUNK: begin
            if (!lkp.hit) begin
               inc.discarded = 1'b1;
            end else begin
               res.slot = tcrt_pkg::slot_bits(lkp.hit_idx);
               upd.en   = 1'b1;
               if (too_large) begin
                  res.status    = tcrt_pkg::ST_TOOLARGE;
                  upd.valid     = 1'b0;
                  inc.discarded = 1'b1;
               end else begin
                  // sizing sticks even when this chunk is discarded
                  upd.sized = 1'b1;
                  upd.total = eff_total;
                  if (total_bad || !place_ok) begin
                     inc.discarded = 1'b1;
                  end else begin
                     res.write_offset = lkp.filled;
                     upd.filled       = new_fill;
                     inc.chunks       = 1'b1;
                     if (new_fill >= eff_total) begin
                        res.status    = tcrt_pkg::ST_COMPLETED;
                        upd.valid     = 1'b0;
                        inc.completed = 1'b1;
                     end else begin
                        res.status = tcrt_pkg::ST_STORED;
                     end
                  end
               end
            end
         end
         tcrt_pkg::ACT_REFUSAL: begin
            if (!lkp.hit) begin
               inc.discarded = 1'b1;
            end else begin
               res.status  = tcrt_pkg::ST_REFUSED;
               res.slot    = tcrt_pkg::slot_bits(lkp.hit_idx);
               inc.refused = 1'b1;
               upd.en      = 1'b1;
               upd.valid   = 1'b0;
            end
         end
         tcrt_pkg::ACT_ABANDON: begin
            res.status = tcrt_pkg::ST_ABANDONED;
            if (lkp.hit) begin
               res.slot  = tcrt_pkg::slot_bits(lkp.hit_idx);
               upd.en    = 1'b1;
               upd.valid = 1'b0;
            end
         end
      endcase

      if (!go) begin
         upd.en = 1'b0;
      end
   end

endmodule

`default_nettype wire

/* rtl/ticketed_chunk_reassembly_tracker.sv */
// Ticketed chunk reassembly tracker: top level with request register, result
// register, tallies and config register. Depends on tcrt_pkg, tcrt_table,
// tcrt_decide and ticketed_chunk_reassembly_tracker_macros.svh.
//
// Usage:
//  - Requests enter on req_* (valid/stall); one result per request leaves on
//    rsp_* (valid/stall), in request order.
//  - csr_* writes max_transfer_bytes; csr_ready is always high. Write it only
//    while no request is in flight.
//  - A request is taken into the request register, decided there against the table
//    and its result captured in the result register unless a held result blocks it.
//  - Throughput: one request per cycle while rsp_stall is low. The table match,
//    free-slot search and entry update all sit between the request register and
//    result register, so each request sees the table left by the one before it.
//  - When rsp_stall is high the result holds, one more request is taken into
//    the request register, and then req_stall rises until the result moves.
//  - Reset (synchronous) empties the table, clears all five tallies and
//    returns max_transfer_bytes to 1048576.
`default_nettype none

`include "ticketed_chunk_reassembly_tracker_macros.svh"

module ticketed_chunk_reassembly_tracker (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [63:0] req_ticket,
   input  wire logic        req_send_ok,
   input  wire logic [31:0] req_total_bytes,
   input  wire logic [31:0] req_chunk_offset,
   input  wire logic [15:0] req_chunk_length,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_status,
   output logic [63:0]      rsp_result_ticket,
   output logic [2:0]       rsp_slot,
   output logic [31:0]      rsp_write_offset,
   output logic [31:0]      rsp_request_count,
   output logic [31:0]      rsp_chunk_count,
   output logic [31:0]      rsp_completed_count,
   output logic [31:0]      rsp_refused_count,
   output logic [31:0]      rsp_discarded_count,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_max_transfer_bytes
);

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_action_ff;
   logic [63:0] in_ticket_ff;
   logic        in_send_ok_ff;
   logic [31:0] in_total_ff;
   logic [31:0] in_offset_ff;
   logic [15:0] in_length_ff;

   logic        out_valid_ff, out_valid_in;
   logic [3:0]  out_status_ff;
   logic [63:0] out_ticket_ff;
   logic [2:0]  out_slot_ff;
   logic [31:0] out_wr_ff;
   logic [31:0] out_req_ff, out_chk_ff, out_cmp_ff, out_ref_ff, out_dis_ff;

   logic [31:0] max_bytes_ff;
   logic [31:0] tally_req_ff, tally_req_in;
   logic [31:0] tally_chk_ff, tally_chk_in;
   logic [31:0] tally_cmp_ff, tally_cmp_in;
   logic [31:0] tally_ref_ff, tally_ref_in;
   logic [31:0] tally_dis_ff, tally_dis_in;

   logic req_take;
   logic advance;

   tcrt_pkg::lookup_type    lkp;
   tcrt_pkg::update_type    upd;
   tcrt_pkg::tally_inc_type inc;
   tcrt_pkg::result_type    res;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   tcrt_table u_table (
      .clock  (clock),
      .reset  (reset),
      .ticket (in_ticket_ff),
      .upd    (upd),
      .lkp    (lkp)
   );

   tcrt_decide u_decide (
      .go           (advance),
      .action       (in_action_ff),
      .ticket       (in_ticket_ff),
      .send_ok      (in_send_ok_ff),
      .total_bytes  (in_total_ff),
      .chunk_offset (in_offset_ff),
      .chunk_length (in_length_ff),
      .max_bytes    (max_bytes_ff),
      .lkp          (lkp),
      .upd          (upd),
      .inc          (inc),
      .res          (res)
   );

   assign tally_req_in = tally_req_ff + 32'(inc.requests);
   assign tally_chk_in = tally_chk_ff + 32'(inc.chunks);
   assign tally_cmp_in = tally_cmp_ff + 32'(inc.completed);
   assign tally_ref_in = tally_ref_ff + 32'(inc.refused);
   assign tally_dis_in = tally_dis_ff + 32'(inc.discarded);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_bytes_ff <= tcrt_pkg::MAX_BYTES_RESET;
         tally_req_ff <= '0;
         tally_chk_ff <= '0;
         tally_cmp_ff <= '0;
         tally_ref_ff <= '0;
         tally_dis_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            max_bytes_ff <= csr_max_transfer_bytes;
         end
         if (advance) begin
            tally_req_ff <= tally_req_in;
            tally_chk_ff <= tally_chk_in;
            tally_cmp_ff <= tally_cmp_in;
            tally_ref_ff <= tally_ref_in;
            tally_dis_ff <= tally_dis_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff  <= req_action;
         in_ticket_ff  <= req_ticket;
         in_send_ok_ff <= req_send_ok;
         in_total_ff   <= req_total_bytes;
         in_offset_ff  <= req_chunk_offset;
         in_length_ff  <= req_chunk_length;
      end
      if (advance) begin
         out_status_ff <= res.status;
         out_ticket_ff <= in_ticket_ff;
         out_slot_ff   <= res.slot;
         out_wr_ff     <= res.write_offset;
         out_req_ff    <= tally_req_in;
         out_chk_ff    <= tally_chk_in;
         out_cmp_ff    <= tally_cmp_in;
         out_ref_ff    <= tally_ref_in;
         out_dis_ff    <= tally_dis_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_result_ticket   = out_ticket_ff;
   assign rsp_slot            = out_slot_ff;
   assign rsp_write_offset    = out_wr_ff;
   assign rsp_request_count   = out_req_ff;
   assign rsp_chunk_count     = out_chk_ff;
   assign rsp_completed_count = out_cmp_ff;
   assign rsp_refused_count   = out_ref_ff;
   assign rsp_discarded_count = out_dis_ff;

   // a blocked result freezes the tallies
   `TCRT_ASSERT_NEXT(a_tally_hold, clock, reset, rsp_valid && rsp_stall, $stable(tally_req_ff) && $stable(tally_dis_ff))
   // stall toward the sender only when the request register is occupied
   `TCRT_ASSERT_IMPLIES(a_stall_occupied, clock, reset, req_stall, in_valid_ff && out_valid_ff)
   // only a stored or completed chunk carries a write offset
   `TCRT_ASSERT_IMPLIES(a_offset_zero, clock, reset, rsp_valid && rsp_status != tcrt_pkg::ST_STORED && rsp_status != tcrt_pkg::ST_COMPLETED, rsp_write_offset == 32'd0)

endmodule

`default_nettype wire

/* sim/tcrt_result_checker.sv */
// Checker for the ticketed chunk reassembly tracker: watches the request, result
// and csr channels, predicts each result and compares it. Depends on tcrt_pkg.
`timescale 1ns / 1ps

module tcrt_result_checker
   import tcrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_ticket,
   input  logic        req_send_ok,
   input  logic [31:0] req_total_bytes,
   input  logic [31:0] req_chunk_offset,
   input  logic [15:0] req_chunk_length,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_status,
   input  logic [63:0] rsp_result_ticket,
   input  logic [2:0]  rsp_slot,
   input  logic [31:0] rsp_write_offset,
   input  logic [31:0] rsp_request_count,
   input  logic [31:0] rsp_chunk_count,
   input  logic [31:0] rsp_completed_count,
   input  logic [31:0] rsp_refused_count,
   input  logic [31:0] rsp_discarded_count,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_max_transfer_bytes,
   output int          fail_count,
   output int          outstanding
);

   typedef struct packed {
      logic [3:0]  status;
      logic [63:0] ticket;
      logic [2:0]  slot;
      logic [31:0] wr_offset;
      logic [31:0] requests;
      logic [31:0] chunks;
      logic [31:0] completed;
      logic [31:0] refused;
      logic [31:0] discarded;
   } tracker_result_t;

   // shadow of the transfer table
   logic        live      [MAX_TRANSFERS];
   logic [63:0] live_tkt  [MAX_TRANSFERS];
   logic        has_total [MAX_TRANSFERS];
   logic [31:0] size_of   [MAX_TRANSFERS];
   logic [31:0] fill_of   [MAX_TRANSFERS];
   logic [31:0] byte_cap;
   logic [31:0] asked_total, stored_total, done_total, refused_total, dropped_total;

   tracker_result_t expected_q[$];
   tracker_result_t want;
   int errors = 0;

   task automatic predict_request(input logic [1:0] act, input logic [63:0] tkt,
                                  input logic ok, input logic [31:0] total,
                                  input logic [31:0] offset, input logic [15:0] len);
      tracker_result_t r;
      status_type      st;
      int              hit;
      int              vacant;
      int              slot_used;
      logic [31:0]     wr;
      hit = -1;
      vacant = -1;
      slot_used = 0;
      wr = '0;
      for (int i = 0; i < MAX_TRANSFERS; i++) begin
         if (hit < 0 && live[i] && live_tkt[i] == tkt) hit = i;
         if (vacant < 0 && !live[i]) vacant = i;
      end
      case (action_type'(act))
         ACT_ASK: begin
            // an open ticket skips the table-full check
            if (hit < 0 && vacant < 0) begin
               st = ST_FULL;
            end else if (!ok) begin
               st = ST_SENDFAIL;
            end else begin
               if (hit < 0) begin
                  hit = vacant;
                  live[hit] = 1'b1;
                  live_tkt[hit] = tkt;
                  has_total[hit] = 1'b0;
                  size_of[hit] = '0;
                  fill_of[hit] = '0;
               end
               asked_total++;
               st = ST_ASKED;
               slot_used = hit;
            end
         end
         ACT_CHUNK: begin
            if (hit < 0) begin
               dropped_total++;
               st = ST_DISCARDED;
            end else begin
               slot_used = hit;
               st = ST_STORED;
               if (!has_total[hit]) begin
                  if (total > byte_cap) begin
                     live[hit] = 1'b0;
                     dropped_total++;
                     st = ST_TOOLARGE;
                  end else begin
                     // sizing sticks even if this chunk is dropped below
                     size_of[hit] = total;
                     has_total[hit] = 1'b1;
                  end
               end else if (size_of[hit] != total) begin
                  st = ST_DISCARDED;
               end
               if (st == ST_STORED && (offset != fill_of[hit] ||
                   33'(fill_of[hit]) + 33'(len) > 33'(size_of[hit])))
                  st = ST_DISCARDED;
               if (st == ST_DISCARDED) begin
                  dropped_total++;
               end else if (st == ST_STORED) begin
                  wr = fill_of[hit];
                  fill_of[hit] = fill_of[hit] + 32'(len);
                  stored_total++;
                  if (fill_of[hit] >= size_of[hit]) begin
                     live[hit] = 1'b0;
                     done_total++;
                     st = ST_COMPLETED;
                  end
               end
            end
         end
         ACT_REFUSAL: begin
            if (hit < 0) begin
               dropped_total++;
               st = ST_DISCARDED;
            end else begin
               live[hit] = 1'b0;
               refused_total++;
               st = ST_REFUSED;
               slot_used = hit;
            end
         end
         default: begin
            if (hit >= 0) begin
               live[hit] = 1'b0;
               slot_used = hit;
            end
            st = ST_ABANDONED;
         end
      endcase
      r.status = st;
      r.ticket = tkt;
      r.slot = 3'(slot_used);
      r.wr_offset = wr;
      r.requests = asked_total;
      r.chunks = stored_total;
      r.completed = done_total;
      r.refused = refused_total;
      r.discarded = dropped_total;
      expected_q.insert(expected_q.size(), r);
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] got_val);
      if (exp_val !== got_val) begin
         errors++;
         if (errors <= 10)
            $display("%0t: %s mismatch, expected %h got %h", $realtime, name,
                     exp_val, got_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TRANSFERS; i++) begin
            live[i] = 1'b0;
            live_tkt[i] = '0;
            has_total[i] = 1'b0;
            size_of[i] = '0;
            fill_of[i] = '0;
         end
         byte_cap = MAX_BYTES_RESET;
         asked_total = '0;
         stored_total = '0;
         done_total = '0;
         refused_total = '0;
         dropped_total = '0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) byte_cap = csr_max_transfer_bytes;
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result with nothing pending, status %0d ticket %h",
                           $realtime, rsp_status, rsp_result_ticket);
            end else begin
               want = expected_q.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("ticket", want.ticket, rsp_result_ticket);
               check_field("slot", 64'(want.slot), 64'(rsp_slot));
               check_field("write_offset", 64'(want.wr_offset), 64'(rsp_write_offset));
               check_field("request_count", 64'(want.requests), 64'(rsp_request_count));
               check_field("chunk_count", 64'(want.chunks), 64'(rsp_chunk_count));
               check_field("completed_count", 64'(want.completed),
                           64'(rsp_completed_count));
               check_field("refused_count", 64'(want.refused), 64'(rsp_refused_count));
               check_field("discarded_count", 64'(want.discarded),
                           64'(rsp_discarded_count));
            end
         end
         if (req_valid && !req_stall)
            predict_request(req_action, req_ticket, req_send_ok, req_total_bytes,
                            req_chunk_offset, req_chunk_length);
      end
      fail_count <= errors;
      outstanding <= expected_q.size();
   end

endmodule

/* sim/ticketed_chunk_reassembly_tracker_tb.sv */
// Testbench top for the ticketed chunk reassembly tracker: clock, reset, request
// traffic, csr writes and verdict. Depends on tcrt_pkg, tcrt_result_checker and ticketed_chunk_reassembly_tracker.
`timescale 1ns / 1ps

module ticketed_chunk_reassembly_tracker_tb;
   import tcrt_pkg::*;

   localparam int STREAMS = 10;
   localparam int STRAYS = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_ASK;
   logic [63:0] req_ticket = '0;
   logic        req_send_ok = 1'b0;
   logic [31:0] req_total_bytes = '0;
   logic [31:0] req_chunk_offset = '0;
   logic [15:0] req_chunk_length = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [63:0] rsp_result_ticket;
   logic [2:0]  rsp_slot;
   logic [31:0] rsp_write_offset;
   logic [31:0] rsp_request_count;
   logic [31:0] rsp_chunk_count;
   logic [31:0] rsp_completed_count;
   logic [31:0] rsp_refused_count;
   logic [31:0] rsp_discarded_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_max_transfer_bytes = '0;

   int fail_count;
   int outstanding;

   int gap_pct = 0;
   int stall_pct = 0;
   int holds_asked = 0;
   int holds_done = 0;
   int hold_left = 0;

   logic [31:0] max_bytes_now = MAX_BYTES_RESET;

   // transfers the traffic generator is driving through the table
   logic [63:0] strm_ticket [STREAMS];
   logic [31:0] strm_total  [STREAMS];
   logic [31:0] strm_sent   [STREAMS];
   logic        strm_open   [STREAMS];
   logic        strm_sized  [STREAMS];
   logic [63:0] stray_ticket [STRAYS];

   always #2 clock = ~clock;

   ticketed_chunk_reassembly_tracker uut (.*);

   tcrt_result_checker checker_i (.*);

   // receiver side: random stalls, plus long hold-offs when asked
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_asked != holds_done) begin
         holds_done <= holds_done + 1;
         hold_left <= 150;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_request(input logic [1:0] act, input logic [63:0] tkt,
                               input logic ok, input logic [31:0] tot,
                               input logic [31:0] off, input logic [15:0] len);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_ticket <= tkt;
      req_send_ok <= ok;
      req_total_bytes <= tot;
      req_chunk_offset <= off;
      req_chunk_length <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_bytes(input logic [31:0] v);
      csr_valid <= 1'b1;
      csr_max_transfer_bytes <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      max_bytes_now = v;
   endtask

   task automatic directed_cases();
      logic [63:0] t_ones;
      t_ones = '1;
      send_request(ACT_ASK, 64'd0, 1'b1, '0, '0, '0);
      send_request(ACT_ASK, 64'd0, 1'b1, '1, '1, '1);    // reopen keeps entry
      send_request(ACT_ASK, 64'd0, 1'b0, '0, '0, '0);    // open ticket, send failed
      send_request(ACT_ASK, t_ones, 1'b0, '0, '0, '0);
      send_request(ACT_CHUNK, t_ones, 1'b1, 32'd10, '0, 16'd10);
      send_request(ACT_REFUSAL, t_ones, 1'b0, '0, '0, '0);
      send_request(ACT_ABANDON, t_ones, 1'b0, '0, '0, '0);
      send_request(ACT_CHUNK, 64'd0, 1'b0, 32'd100, 32'd0, 16'd40);
      send_request(ACT_CHUNK, 64'd0, 1'b0, 32'd101, 32'd40, 16'd10);  // total changed
      send_request(ACT_CHUNK, 64'd0, 1'b0, 32'd100, 32'd10, 16'd10);  // bad offset
      send_request(ACT_CHUNK, 64'd0, 1'b0, 32'd100, 32'd40, 16'd100); // runs past total
      send_request(ACT_CHUNK, 64'd0, 1'b0, 32'd100, 32'd40, 16'd60);
      send_request(ACT_ASK, t_ones, 1'b1, '0, '0, '0);
      send_request(ACT_CHUNK, t_ones, 1'b1, '1, '1, '1);              // too large
      send_request(ACT_ASK, 64'h5, 1'b1, '0, '0, '0);
      send_request(ACT_CHUNK, 64'h5, 1'b0, 32'd0, 32'd0, 16'd0);      // zero total
      send_request(ACT_ASK, 64'h6, 1'b1, '0, '0, '0);
      send_request(ACT_CHUNK, 64'h6, 1'b0, 32'd50, 32'd5, 16'd0);     // sizes, dropped
      send_request(ACT_CHUNK, 64'h6, 1'b0, 32'd50, 32'd0, 16'd50);
      send_request(ACT_ASK, 64'h7, 1'b1, '0, '0, '0);
      send_request(ACT_REFUSAL, 64'h7, 1'b1, '0, '0, '0);
      for (int i = 0; i < MAX_TRANSFERS; i++)
         send_request(ACT_ASK, 64'h0123_4567_89AB_0000 + i, 1'b1, '0, '0, '0);
      send_request(ACT_ASK, 64'h0123_4567_89AB_FFFF, 1'b0, '0, '0, '0); // table full
      send_request(ACT_ASK, 64'h0123_4567_89AB_0003, 1'b1, '0, '0, '0);
      for (int i = 0; i < MAX_TRANSFERS; i++)
         send_request(ACT_ABANDON, 64'h0123_4567_89AB_0000 + i, 1'b0, '0, '0, '0);
   endtask

   task automatic pick_total(input int s);
      int r;
      r = $urandom_range(9);
      if (r < 2)
         strm_total[s] = $urandom_range(8);
      else if (r < 7)
         strm_total[s] = $urandom_range(3000, 1);
      else if (r == 7)
         strm_total[s] = $urandom_range(20000, 3001);
      else if (r == 8 && max_bytes_now != '1)
         strm_total[s] = max_bytes_now + 1;
      else
         strm_total[s] = $urandom;
   endtask

   task automatic advance_stream(input int s);
      logic [31:0] rem;
      logic [31:0] off;
      logic [31:0] tot;
      logic [15:0] len;
      int          c;
      rem = strm_total[s] - strm_sent[s];
      len = (rem > 700) ? 16'($urandom_range(700)) : 16'($urandom_range(rem));
      off = strm_sent[s];
      tot = strm_total[s];
      c = strm_sized[s] ? $urandom_range(19) : 99;
      if (c == 0)
         off = off + 1 + $urandom_range(50);
      else if (c == 1)
         tot = tot ^ (32'd1 << $urandom_range(31));
      else if (c == 2 && rem < 60000)
         len = 16'(rem + 1 + $urandom_range(100));
      else
         strm_sent[s] = strm_sent[s] + 32'(len);
      send_request(ACT_CHUNK, strm_ticket[s], 1'($urandom), tot, off, len);
      strm_sized[s] = 1'b1;
      if (strm_sent[s] == strm_total[s] || strm_total[s] > max_bytes_now)
         strm_open[s] = 1'b0;
   endtask

   task automatic random_traffic(input int count);
      int          k;
      int          s;
      logic [63:0] tkt;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(99);
         s = $urandom_range(STREAMS - 1);
         if (k < 70) begin
            if (!strm_open[s]) begin
               strm_ticket[s] = {$urandom, $urandom};
               pick_total(s);
               strm_sent[s] = '0;
               strm_open[s] = 1'b1;
               strm_sized[s] = 1'b0;
               send_request(ACT_ASK, strm_ticket[s], $urandom_range(9) != 0,
                            $urandom, $urandom, 16'($urandom));
            end else begin
               advance_stream(s);
            end
         end else if (k < 80) begin
            send_request(k < 75 ? ACT_ABANDON : ACT_REFUSAL, strm_ticket[s], 1'($urandom),
                         $urandom, $urandom, 16'($urandom));
            strm_open[s] = 1'b0;
         end else begin
            // noise: any action on a stray or fully random ticket
            tkt = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                           : stray_ticket[$urandom_range(STRAYS - 1)];
            send_request(2'($urandom), tkt, 1'($urandom), $urandom, $urandom,
                         16'($urandom));
         end
      end
   endtask

   task automatic close_everything();
      for (int s = 0; s < STREAMS; s++) begin
         send_request(ACT_ABANDON, strm_ticket[s], 1'b0, '0, '0, '0);
         strm_open[s] = 1'b0;
      end
      for (int i = 0; i < STRAYS; i++)
         send_request(ACT_ABANDON, stray_ticket[i], 1'b0, '0, '0, '0);
   endtask

   initial begin
      for (int s = 0; s < STREAMS; s++) begin
         strm_ticket[s] = {$urandom, $urandom};
         strm_total[s] = '0;
         strm_sent[s] = '0;
         strm_open[s] = 1'b0;
         strm_sized[s] = 1'b0;
      end
      for (int i = 0; i < STRAYS; i++) stray_ticket[i] = {$urandom, $urandom};
      stray_ticket[0] = '0;
      stray_ticket[1] = '1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_cases();
      for (int phase = 0; phase < 5; phase++) begin
         wait_for_results();
         case (phase)
            0: write_max_bytes(32'd0);
            1: write_max_bytes(32'hFFFF_FFFF);
            2: write_max_bytes(32'd1500);
            3: write_max_bytes(MAX_BYTES_RESET);
            default: write_max_bytes($urandom_range(4000, 200));
         endcase
         case (phase)
            1: begin gap_pct = 77; stall_pct = 0; end
            2: begin gap_pct = 0; stall_pct = 77; end
            3: begin gap_pct = 13; stall_pct = 13; end
            default: begin gap_pct = 0; stall_pct = 0; end
         endcase
         // long receiver hold-off while requests keep coming
         if (phase == 0) holds_asked <= holds_asked + 1;
         random_traffic(105);
         close_everything();
      end
      wait_for_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
